>>> rtl/sacc_pkg.sv
// types, constants and arithmetic helpers of the stretched allpass cascade
// depends on nothing; imported by the channel interfaces and the top level
package sacc_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned COEF_W     = 17;
  localparam int unsigned PROD_W     = SAMPLE_W + COEF_W;
  localparam int unsigned RND_W      = PROD_W - 15;
  localparam int unsigned SUM_W      = RND_W + 1;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = COEF_W;
  localparam int unsigned DELAY_W    = 4;
  localparam int unsigned COUNT_W    = 7;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [RND_W-1:0]    rnd_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_OUTER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_INNER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_K     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT = 2'd3;

  localparam sample_t SAMPLE_MAX = 24'sh7fffff;
  localparam sample_t SAMPLE_MIN = 24'sh800000;

  // product by a q1.16 coefficient rounded to nearest, ties up
  function automatic rnd_t rnd_q16(input prod_t p);
    logic signed [PROD_W:0] t;
    t = (PROD_W+1)'(p) + (PROD_W+1)'(32768);
    return t[PROD_W:16];
  endfunction

  function automatic sample_t sat24(input sum_t v);
    if (v > SUM_W'(SAMPLE_MAX)) begin
      return SAMPLE_MAX;
    end else if (v < SUM_W'(SAMPLE_MIN)) begin
      return SAMPLE_MIN;
    end
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

>>> rtl/sacc_stream_if.sv
// valid/ready sample channels of the stretched allpass cascade
// depends on sacc_pkg
interface sacc_in_if;
  import sacc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

interface sacc_out_if;
  import sacc_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink (input valid, input sample_out, output ready);
endinterface

>>> rtl/stretched_allpass_chirp_cascade.sv
// top level of the stretched allpass cascade, the chirp filter of one spring
// depends on sacc_pkg, sacc_stream_if and sacc_ram
//
// one signed q1.23 sample enters on in_i and one filtered sample leaves on out_o,
// both valid/ready channels; a transfer happens when valid and ready are high.
// the user must write coefficients, delay_k and stage_count (cfg_we_i/cfg_idx_i/
// cfg_data_i) only while no sample is in flight; the block does not enforce it.
// the delay lines sit in one ram of NUM_STAGES*STORE_DEPTH words and the inner
// states in a ram of NUM_STAGES words; each stage reads both, runs through
// two shared multipliers and writes back when its valid bit reaches vf_q.
// a new stage is issued whenever phase_q returns to zero, paced by the outer
// recursion (subtract, multiply, add) that feeds the next stage.
// an accepted sample passes ST_RUN, skipped when no stage is active, and ST_DONE
// before out_q and out_o.valid are loaded; one sample is processed at a time, so
// a new sample is taken only after the previous result has been loaded.
// after reset ST_CLR zeroes both rams, stepping clr_q through all
// NUM_STAGES*STORE_DEPTH delay line words, while in_i.ready stays low.
// the result sits in an output register: the next sample is taken while it
// waits, and a stalled receiver only holds the next result back.
module stretched_allpass_chirp_cascade #(
  parameter int unsigned NUM_STAGES  = 64,
  parameter int unsigned STORE_DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sacc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sacc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  sacc_in_if.sink                          in_i,
  sacc_out_if.source                       out_o
);
  import sacc_pkg::*;

  localparam int unsigned TOTAL = NUM_STAGES * STORE_DEPTH;
  localparam int unsigned AW    = $clog2(TOTAL);
  localparam int unsigned SW    = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
  localparam int unsigned PW    = $clog2(STORE_DEPTH);
  localparam int unsigned NW    = ($clog2(NUM_STAGES + 1) > COUNT_W) ?
                                  $clog2(NUM_STAGES + 1) : COUNT_W;
  localparam int unsigned NDLY  = 2 ** DELAY_W;

  typedef enum logic [1:0] {
    ST_CLR,
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic [AW-1:0]        clr_q;
  logic [PW-1:0]        wp_q;
  logic [PW-1:0]        rdp_q;
  logic [NW-1:0]        n_q;
  logic [NW-1:0]        iss_q;
  logic [NW-1:0]        wr_q;
  logic [AW-1:0]        base_q;
  logic [AW-1:0]        wbase_q;
  logic [1:0]           phase_q;
  logic                 vb_q, vc_q, vd_q, ve_q, vf_q;
  logic                 out_valid_q;

  coef_t                a1_q, a2_q;
  logic [DELAY_W-1:0]   dly_q;
  logic [COUNT_W-1:0]   cnt_q;

  sample_t              y_q, m_q, sm_q, smf_q, s1_q, s2_q, out_q;
  prod_t                p1_q, p2_q;

  logic [PW-1:0]        dmod_tbl [NDLY];
  logic [PW-1:0]        dm;
  logic [PW:0]          wrap_sum;
  logic [PW-1:0]        rdp_d;
  logic [NW-1:0]        n_d;
  logic                 accept;
  logic                 issue;
  logic                 load_out;
  sample_t              mul1_b, mul2_b;
  prod_t                mul1_p, mul2_p;
  sample_t              s1_d, s2_d, y1_d, y2_d;

  logic                 st_we, st_re, in_we;
  logic [AW-1:0]        st_waddr, st_raddr;
  logic [SW-1:0]        in_waddr, in_raddr;
  sample_t              st_wdata, in_wdata, st_rdata, in_rdata;

  for (genvar gi = 0; gi < NDLY; gi++) begin : g_dmod
    assign dmod_tbl[gi] = PW'(gi % STORE_DEPTH);
  end

  assign dm       = dmod_tbl[dly_q];
  assign wrap_sum = {1'b0, wp_q} + (PW+1)'(STORE_DEPTH) - {1'b0, dm};
  assign rdp_d    = (wp_q >= dm) ? (wp_q - dm) : wrap_sum[PW-1:0];
  assign n_d      = (NW'(cnt_q) > NW'(NUM_STAGES)) ? NW'(NUM_STAGES) : NW'(cnt_q);

  assign in_i.ready       = (state_q == ST_IDLE);
  assign accept           = in_i.valid && in_i.ready;
  assign issue            = (state_q == ST_RUN) && (phase_q == 2'd0) && (iss_q < n_q);
  assign load_out         = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);
  assign out_o.valid      = out_valid_q;
  assign out_o.sample_out = out_q;

  // shared multipliers, the two users of each never meet in one cycle
  assign mul1_b = vb_q ? sample_t'(st_rdata) : s1_q;
  assign mul2_b = vc_q ? sm_q : s2_q;
  assign mul1_p = a1_q * mul1_b;
  assign mul2_p = a2_q * mul2_b;

  assign s1_d = sat24(SUM_W'(y_q) - SUM_W'(rnd_q16(p1_q)));
  assign s2_d = sat24(SUM_W'(s1_q) - SUM_W'(rnd_q16(p2_q)));
  assign y1_d = sat24(SUM_W'(rnd_q16(p1_q)) + SUM_W'(m_q));
  assign y2_d = sat24(SUM_W'(rnd_q16(p2_q)) + SUM_W'(smf_q));

  always_comb begin
    if (state_q == ST_CLR) begin
      st_we    = 1'b1;
      st_waddr = clr_q;
      st_wdata = '0;
      in_we    = (clr_q < AW'(NUM_STAGES));
      in_waddr = clr_q[SW-1:0];
      in_wdata = '0;
    end else begin
      st_we    = vf_q;
      st_waddr = wbase_q + AW'(wp_q);
      st_wdata = y2_d;
      in_we    = vf_q;
      in_waddr = wr_q[SW-1:0];
      in_wdata = s2_q;
    end
  end

  assign st_re    = issue;
  assign st_raddr = base_q + AW'(rdp_q);
  assign in_raddr = iss_q[SW-1:0];

  sacc_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(TOTAL)
  ) u_stretch_ram (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  sacc_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(NUM_STAGES)
  ) u_inner_ram (
    .clk_i  (clk_i),
    .we_i   (in_we),
    .waddr_i(in_waddr),
    .wdata_i(in_wdata),
    .re_i   (issue),
    .raddr_i(in_raddr),
    .rdata_o(in_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q  <= '0;
      a2_q  <= '0;
      dly_q <= DELAY_W'(1);
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COEF_OUTER:  a1_q  <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_INNER:  a2_q  <= cfg_data_i[COEF_W-1:0];
        CFG_DELAY_K:     dly_q <= cfg_data_i[DELAY_W-1:0];
        CFG_STAGE_COUNT: cnt_q <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      wp_q        <= '0;
      rdp_q       <= '0;
      n_q         <= '0;
      iss_q       <= '0;
      wr_q        <= '0;
      base_q      <= '0;
      wbase_q     <= '0;
      phase_q     <= '0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      vd_q        <= 1'b0;
      ve_q        <= 1'b0;
      vf_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      vb_q <= issue;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
      vf_q <= ve_q;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(TOTAL - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            rdp_q   <= rdp_d;
            n_q     <= n_d;
            iss_q   <= '0;
            wr_q    <= '0;
            base_q  <= '0;
            wbase_q <= '0;
            phase_q <= '0;
            state_q <= (n_d == '0) ? ST_DONE : ST_RUN;
          end
        end
        ST_RUN: begin
          phase_q <= (phase_q == 2'd2) ? 2'd0 : phase_q + 2'd1;
          if (issue) begin
            iss_q  <= iss_q + 1'b1;
            base_q <= base_q + AW'(STORE_DEPTH);
          end
          if (vf_q) begin
            wr_q    <= wr_q + 1'b1;
            wbase_q <= wbase_q + AW'(STORE_DEPTH);
            if (wr_q + 1'b1 == n_q) begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (load_out) begin
            wp_q    <= (wp_q == PW'(STORE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_CLR;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      y_q <= in_i.sample_in;
    end
    if (vb_q) begin
      m_q  <= st_rdata;
      sm_q <= in_rdata;
      p1_q <= mul1_p;
    end
    if (vc_q) begin
      s1_q <= s1_d;
      p2_q <= mul2_p;
    end
    if (vd_q) begin
      p1_q <= mul1_p;
      s2_q <= s2_d;
    end
    if (ve_q) begin
      y_q   <= y1_d;
      p2_q  <= mul2_p;
      smf_q <= sm_q;
    end
    if (load_out) begin
      out_q <= y_q;
    end
  end

  a_mul1_shared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vb_q && vd_q))
    else $error("outer multiplier claimed twice");

  a_mul2_shared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vc_q && ve_q))
    else $error("inner multiplier claimed twice");

  a_ram_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(vf_q && issue))
    else $error("stage read and write back in the same cycle");

  a_wb_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (wr_q <= iss_q))
    else $error("write back ahead of stage issue");

  a_done_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> !(vb_q || vc_q || vd_q || ve_q || vf_q))
    else $error("result taken with a stage still in flight");

endmodule

>>> rtl/sacc_ram.sv
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
module sacc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
